// ===== hdl/kmht_pkg.sv =====
// Shared constants, types and helpers for the keypad matrix hold tracker.
`timescale 1ns / 1ps

package kmht_pkg;

  // Matrix geometry and list size
  localparam int ROWS         = 4;
  localparam int COLS         = 4;
  localparam int NKEYS        = ROWS * COLS;
  localparam int LIST_SLOTS   = 6;
  localparam int REPORT_SLOTS = 2;

  localparam int KEY_W      = $clog2(NKEYS);
  localparam int POS_W      = $clog2(NKEYS + 1);
  localparam int CODE_W     = 5;
  localparam int CNT_W      = 3;
  localparam int MODE_W     = 2;
  localparam int TIMER_W    = 17;
  localparam int INTERVAL_W = 10;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  // Key modes
  localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOWN     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 1'b1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd50;
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = 16'd3000;

  // Per-key status after a tick
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              changed;
  } lane_t;

  // One result item; last member sits in the lowest bits
  typedef struct packed {
    logic [NKEYS-1:0]  held_map;
    logic [NKEYS-1:0]  changed_map;
    logic              any_changed;
    logic              second_changed;
    logic [MODE_W-1:0] second_state;
    logic [CODE_W-1:0] second_code;
    logic              first_changed;
    logic [MODE_W-1:0] first_state;
    logic [CODE_W-1:0] first_code;
    logic [CNT_W-1:0]  key_count;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // Ordinal position to list slot, modulo LIST_SLOTS, as a small table
  function automatic logic [CNT_W-1:0] slot_of(input logic [POS_W-1:0] pos);
    logic [CNT_W-1:0] slot;
    slot = '0;
    for (int i = 0; i <= NKEYS; i++) begin
      if (pos == POS_W'(i)) begin
        slot = CNT_W'(i % LIST_SLOTS);
      end
    end
    return slot;
  endfunction

endpackage

// ===== hdl/kmht_lane.sv =====
// One key lane: mode and hold timer of a single matrix key.
`timescale 1ns / 1ps

module kmht_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc_i,
  input  logic                                pressed_i,
  input  logic [kmht_pkg::INTERVAL_W-1:0]     interval_i,
  input  logic [kmht_pkg::THRESH_W-1:0]       threshold_i,
  output kmht_pkg::lane_t                     lane_o
);
  import kmht_pkg::*;

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sat;

  always_comb begin
    sum       = {1'b0, timer_r} + (TIMER_W + 1)'(interval_i);
    sat       = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    mode_nxt  = mode_r;
    timer_nxt = timer_r;
    if (pressed_i) begin
      if (mode_r == MODE_RELEASED) begin
        mode_nxt  = MODE_DOWN;
        timer_nxt = '0;
      end else if (mode_r == MODE_DOWN) begin
        timer_nxt = sat;
        if (sat > TIMER_W'(threshold_i)) begin
          mode_nxt = MODE_HOLD;
        end
      end
    end else if (mode_r == MODE_DOWN || mode_r == MODE_HOLD) begin
      mode_nxt = MODE_RELEASED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RELEASED;
      timer_r <= '0;
    end else if (acc_i) begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
    end
  end

  assign lane_o.mode    = mode_nxt;
  assign lane_o.changed = (mode_nxt != mode_r);

`ifndef SYNTH
  // A held key keeps its timer frozen
  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i && pressed_i && mode_r == MODE_HOLD |=> timer_r == $past(timer_r))
    else $error("hold timer moved while key in hold");
`endif

endmodule

// ===== hdl/kmht_merge.sv =====
// Merge stage: key list slots, count and per-tick maps from all lanes.
`timescale 1ns / 1ps

module kmht_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc_i,
  input  logic [kmht_pkg::NKEYS-1:0]      map_i,
  input  kmht_pkg::lane_t                 lanes_i [kmht_pkg::NKEYS],
  output kmht_pkg::result_t               result_o
);
  import kmht_pkg::*;

  logic [CODE_W-1:0] slot_code_r [REPORT_SLOTS];
  logic [CODE_W-1:0] slot_code_nxt [REPORT_SLOTS];
  logic [KEY_W-1:0]  slot_key_r [REPORT_SLOTS];
  logic [KEY_W-1:0]  slot_key_nxt [REPORT_SLOTS];
  logic [POS_W-1:0]  pos [NKEYS];
  logic [NKEYS-1:0]  chg_map;
  logic [NKEYS-1:0]  hold_map;
  logic [MODE_W-1:0] rep_state [REPORT_SLOTS];
  logic              rep_chg [REPORT_SLOTS];

  // Ordinal of each pressed key among the pressed keys before it
  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      pos[k] = POS_W'($countones(map_i & ((NKEYS'(1) << k) - NKEYS'(1))));
    end
  end

  // Last pressed key landing on each reported slot wins
  always_comb begin
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      slot_code_nxt[s] = slot_code_r[s];
      slot_key_nxt[s]  = slot_key_r[s];
    end
    if (acc_i) begin
      for (int c = 0; c < COLS; c++) begin
        for (int r = 0; r < ROWS; r++) begin
          for (int s = 0; s < REPORT_SLOTS; s++) begin
            if (map_i[c*ROWS+r] && slot_of(pos[c*ROWS+r]) == CNT_W'(s)) begin
              slot_code_nxt[s] = CODE_W'(r*COLS + c + 1);
              slot_key_nxt[s]  = KEY_W'(c*ROWS + r);
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      chg_map[k]  = lanes_i[k].changed;
      hold_map[k] = (lanes_i[k].mode == MODE_HOLD);
    end
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      rep_state[s] = MODE_RELEASED;
      rep_chg[s]   = 1'b0;
      if (slot_code_nxt[s] != '0) begin
        rep_state[s] = lanes_i[slot_key_nxt[s]].mode;
        rep_chg[s]   = lanes_i[slot_key_nxt[s]].changed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < REPORT_SLOTS; s++) begin
        slot_code_r[s] <= '0;
        slot_key_r[s]  <= '0;
      end
    end else begin
      for (int s = 0; s < REPORT_SLOTS; s++) begin
        slot_code_r[s] <= slot_code_nxt[s];
        slot_key_r[s]  <= slot_key_nxt[s];
      end
    end
  end

  always_comb begin
    result_o.key_count      = slot_of(POS_W'($countones(map_i)));
    result_o.first_code     = slot_code_nxt[0];
    result_o.first_state    = rep_state[0];
    result_o.first_changed  = rep_chg[0];
    result_o.second_code    = slot_code_nxt[1];
    result_o.second_state   = rep_state[1];
    result_o.second_changed = rep_chg[1];
    result_o.any_changed    = |chg_map;
    result_o.changed_map    = chg_map;
    result_o.held_map       = hold_map;
  end

`ifndef SYNTH
  // The first pressed key of a tick always lands in slot zero
  a_slot0_filled: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i && map_i != '0 |=> slot_code_r[0] != '0)
    else $error("slot zero empty after a tick with a press");

  // Slot codes stay within the key range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_code_r[1] <= CODE_W'(NKEYS) && slot_code_r[0] <= CODE_W'(NKEYS))
    else $error("slot code out of range");
`endif

endmodule

// ===== hdl/keypad_matrix_hold_tracker.sv =====
// Top level of the keypad matrix hold tracker: lanes, merge and output buffer.
`timescale 1ns / 1ps

// Each input transfer is one scan tick of the 4x4 key matrix; each tick yields
// exactly one result transfer. Sixteen key lanes update their mode and hold
// timer side by side and the merge stage builds the key list, the count and
// the change and hold maps in the same cycle, so a tick is taken every clock
// while in_tready is high, and its result is registered into the output
// buffer. A two-entry output buffer (output register plus skid register) lets
// the input keep taking ticks while a result waits; in_tready drops only once
// both entries hold results. Write cfg registers only while the block is idle:
// index 0 is the scan interval in ms (10 bits), index 1 the hold threshold in
// ms (16 bits). Reset restores 50 ms and 3000 ms, all keys released and the
// key list empty.

module keypad_matrix_hold_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [15:0] pressed_map
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kmht_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [2:0] key_count, [7:3] first_code, [9:8] first_state,
  // [10] first_changed, [15:11] second_code, [17:16] second_state,
  // [18] second_changed, [19] any_changed, [35:20] changed_map,
  // [51:36] held_map, [55:52] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kmht_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [kmht_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [kmht_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kmht_pkg::*;

  logic [INTERVAL_W-1:0] interval_r;
  logic [THRESH_W-1:0]   threshold_r;
  logic                  acc;
  lane_t                 lanes [NKEYS];
  result_t               result;
  result_t               out_r;
  result_t               skid_r;
  logic                  out_v_r;
  logic                  skid_v_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RESET;
      threshold_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SCAN_INTERVAL:  interval_r  <= cfg_wdata[INTERVAL_W-1:0];
        REG_HOLD_THRESHOLD: threshold_r <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a tick whenever the skid entry is free
  assign in_tready = !skid_v_r;
  assign acc       = in_tvalid && in_tready;

  // One lane per matrix key
  for (genvar k = 0; k < NKEYS; k++) begin : g_lane
    kmht_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .acc_i       (acc),
      .pressed_i   (in_tdata[k]),
      .interval_i  (interval_r),
      .threshold_i (threshold_r),
      .lane_o      (lanes[k])
    );
  end

  kmht_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (acc),
    .map_i    (in_tdata[NKEYS-1:0]),
    .lanes_i  (lanes),
    .result_o (result)
  );

  // Output register with skid entry: advance when the output is free,
  // otherwise park the new result in the skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= acc;
      end
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= result;
      end
    end else if (acc) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W - RESULT_W)'(0), out_r};

`ifndef SYNTH
  // The skid entry is only filled behind a waiting output result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result with the output empty");

  // A transfer into a free output shows up on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (!out_v_r || out_tready) |=> out_tvalid && !skid_v_r)
    else $error("result lost after input transfer");

  // A stalled output with a parked result keeps both entries
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && skid_v_r |=> out_v_r && skid_v_r)
    else $error("buffered result dropped under stall");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the keypad matrix hold tracker.
`timescale 1ns / 1ps

module tb;
  import kmht_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  keypad_matrix_hold_tracker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] pressed_map
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // key_count, first_*, second_*, any_changed, maps
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the tracker: per-key mode and timer, the key list, the
  // settings currently programmed.
  logic [MODE_W-1:0]     shadow_mode    [NKEYS];
  logic [TIMER_W-1:0]    shadow_timer   [NKEYS];
  logic                  shadow_changed [NKEYS];
  logic [CODE_W-1:0]     shadow_slot    [LIST_SLOTS];
  logic [INTERVAL_W-1:0] shadow_interval;
  logic [THRESH_W-1:0]   shadow_threshold;

  // Results predicted for accepted scan ticks, oldest first
  result_t pending_results[$];

  int  mismatch_count;
  int  cycle_count;
  bit  quiet;        // no random idle gaps on either side while set
  int  stall_left;   // receiver hold-off, counted down by the receiver

  // Mode and change flag of the key named by one list slot; an empty slot
  // reports released and unchanged.
  task automatic slot_status(input int slot, output logic [CODE_W-1:0] code,
                             output logic [MODE_W-1:0] mode, output logic chg);
    int lin;
    int k;
    code = shadow_slot[slot];
    mode = MODE_RELEASED;
    chg  = 1'b0;
    if (code != 0 && code <= NKEYS) begin
      lin  = code - 1;
      k    = (lin % COLS) * ROWS + (lin / COLS);
      mode = shadow_mode[k];
      chg  = shadow_changed[k];
    end
  endtask

  // Advance the shadow by one scan tick and return the result it yields.
  task automatic track_scan(input logic [IN_DATA_W-1:0] map, output result_t res);
    int                unsigned cnt;
    int                k;
    logic [MODE_W-1:0] prior;
    logic [TIMER_W:0]  sum;
    cnt = 0;
    res = '0;
    // Scan order: column outer, row inner
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        k     = c * ROWS + r;
        prior = shadow_mode[k];
        if (map[k]) begin
          shadow_slot[cnt] = CODE_W'(r * COLS + c + 1);
          cnt = (cnt + 1) % LIST_SLOTS;
          if (prior == MODE_RELEASED) begin
            shadow_mode[k]  = MODE_DOWN;
            shadow_timer[k] = '0;
          end else if (prior == MODE_DOWN) begin
            // Saturate rather than wrap; hold once the timer passes the bound
            sum = {1'b0, shadow_timer[k]} + shadow_interval;
            if (sum > TIMER_MAX) sum = {1'b0, TIMER_MAX};
            shadow_timer[k] = sum[TIMER_W-1:0];
            if (sum > shadow_threshold) shadow_mode[k] = MODE_HOLD;
          end
          // A key already in hold stays there with its timer frozen
        end else if (prior == MODE_DOWN || prior == MODE_HOLD) begin
          shadow_mode[k] = MODE_RELEASED;
        end
        shadow_changed[k]  = (shadow_mode[k] != prior);
        res.changed_map[k] = shadow_changed[k];
        res.held_map[k]    = (shadow_mode[k] == MODE_HOLD);
      end
    end
    res.key_count   = CNT_W'(cnt);
    res.any_changed = |res.changed_map;
    slot_status(0, res.first_code, res.first_state, res.first_changed);
    slot_status(1, res.second_code, res.second_state, res.second_changed);
  endtask

  // Offer one scan tick, maybe after a few idle cycles, and hold it until
  // the transfer happens. Returns right after the accepting edge.
  task automatic send_scan(input logic [IN_DATA_W-1:0] map);
    int      gap;
    result_t res;
    gap = 0;
    // Each offered cycle idles with the same odds, about a quarter
    if (!quiet) begin
      while ($urandom_range(99) < 26) gap++;
    end
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = IN_DATA_W'($urandom);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = map;
    do @(posedge clk); while (!in_tready);
    track_scan(map, res);
    pending_results.push_back(res);
  endtask

  // Program one register once every outstanding result has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_SCAN_INTERVAL) shadow_interval = value[INTERVAL_W-1:0];
    else shadow_threshold = value[THRESH_W-1:0];
  endtask

  task automatic set_timing(input int interval, input int threshold);
    write_reg(REG_SCAN_INTERVAL, CFG_DATA_W'(interval));
    write_reg(REG_HOLD_THRESHOLD, CFG_DATA_W'(threshold));
  endtask

  // Mostly well-formed press runs: a small set of keys held for a while,
  // with the odd glitch or extra key; the rest is random noise.
  task automatic run_press_runs(input int n_items, input int max_run);
    int                   sent;
    int                   run_len;
    int                   nkeys;
    logic [IN_DATA_W-1:0] held_set;
    logic [IN_DATA_W-1:0] map;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20) begin
        send_scan(IN_DATA_W'($urandom));
        sent++;
      end else begin
        held_set = '0;
        nkeys    = $urandom_range(1, 7);
        repeat (nkeys) held_set[$urandom_range(NKEYS - 1)] = 1'b1;
        run_len = $urandom_range(1, max_run);
        for (int i = 0; i < run_len && sent < n_items; i++) begin
          map = held_set;
          if ($urandom_range(9) == 0) map[$urandom_range(NKEYS - 1)] ^= 1'b1;
          if ($urandom_range(7) == 0) map |= IN_DATA_W'($urandom & $urandom);
          send_scan(map);
          sent++;
        end
      end
    end
  endtask

  // Directed ticks at reset settings: empty matrix, all keys (count wraps to
  // four), stale slots after release, corner keys, exactly six and seven keys.
  task automatic test_directed_defaults();
    send_scan(16'h0000);
    send_scan(16'hFFFF);
    send_scan(16'hFFFF);
    send_scan(16'h0000);
    send_scan(16'h0001);
    send_scan(16'h8000);
    send_scan(16'h003F);
    send_scan(16'h007F);
    send_scan(16'h5A5A);
    send_scan(16'hA5A5);
    send_scan(16'h0000);
  endtask

  // Directed hold transitions at the interval and threshold extremes.
  task automatic test_directed_hold();
    set_timing(1023, 0);
    send_scan(16'h0001);   // released to down
    send_scan(16'h0001);   // timer passes zero: hold
    send_scan(16'h0003);   // hold stays, second key goes down
    send_scan(16'h0002);   // first key released from hold
    send_scan(16'h0000);
    set_timing(1, 1);
    send_scan(16'h8000);
    send_scan(16'h8000);   // timer 1, not above threshold
    send_scan(16'h8000);   // timer 2: hold
    send_scan(16'h0000);
  endtask

  // Random runs at reset settings; long runs reach hold after 61 ticks.
  task automatic test_default_timing();
    set_timing(INTERVAL_RESET, THRESH_RESET);
    run_press_runs(300, 80);
  endtask

  // Largest threshold with the largest interval: hold after 65 ticks.
  task automatic test_threshold_max();
    set_timing(1023, 65535);
    for (int i = 0; i < 70; i++) send_scan(16'h0410 | IN_DATA_W'($urandom_range(1) << 2));
    send_scan(16'h0000);
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_no_idle();
    set_timing($urandom_range(1, 1023), $urandom_range(0, 4000));
    quiet = 1'b1;
    run_press_runs(150, 30);
    quiet = 1'b0;
  endtask

  // Hold off the receiver while ticks keep coming so the output buffer fills
  // and the input stalls.
  task automatic test_output_backpressure();
    quiet = 1'b1;
    send_scan(IN_DATA_W'($urandom));
    stall_left = 300;
    repeat (24) send_scan(IN_DATA_W'($urandom));
    quiet = 1'b0;
  endtask

  // Several random settings, thresholds scaled so holds are reachable.
  task automatic test_random_timing();
    int interval;
    int threshold;
    for (int p = 0; p < 4; p++) begin
      interval  = $urandom_range(1, 1023);
      threshold = interval * $urandom_range(0, 30);
      if (threshold > 65535) threshold = 65535;
      set_timing(interval, threshold);
      run_press_runs(150, 40);
    end
    set_timing(1, $urandom_range(0, 20));
    run_press_runs(100, 40);
  endtask

  // Drive the receiver's ready at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left = stall_left - 1;
    end else if (quiet) begin
      out_tready = 1'b1;
    end else begin
      out_tready = ($urandom_range(99) >= 26);
    end
  end

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("result transfer with no scan tick outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("key_count", 16'(want.key_count), 16'(got.key_count));
        check_field("first_code", 16'(want.first_code), 16'(got.first_code));
        check_field("first_state", 16'(want.first_state), 16'(got.first_state));
        check_field("first_changed", 16'(want.first_changed), 16'(got.first_changed));
        check_field("second_code", 16'(want.second_code), 16'(got.second_code));
        check_field("second_state", 16'(want.second_state), 16'(got.second_state));
        check_field("second_changed", 16'(want.second_changed),
                    16'(got.second_changed));
        check_field("any_changed", 16'(want.any_changed), 16'(got.any_changed));
        check_field("changed_map", want.changed_map, got.changed_map);
        check_field("held_map", want.held_map, got.held_map);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = REG_SCAN_INTERVAL;
    cfg_wdata  = '0;
    quiet      = 1'b0;
    stall_left = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int k = 0; k < NKEYS; k++) begin
      shadow_mode[k]    = MODE_RELEASED;
      shadow_timer[k]   = '0;
      shadow_changed[k] = 1'b0;
    end
    for (int s = 0; s < LIST_SLOTS; s++) shadow_slot[s] = '0;
    shadow_interval  = INTERVAL_RESET;
    shadow_threshold = THRESH_RESET;

    // Hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_defaults();
    test_directed_hold();
    test_default_timing();
    test_threshold_max();
    test_no_idle();
    test_output_backpressure();
    test_random_timing();

    // Drain, then allow a few cycles for any stray transfer
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
